FILE: design/lattice_neighbour_index_generator_macros.svh
// ----------------------------------------------------------------------------
// lattice neighbour index generator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LATTICE_NEIGHBOUR_INDEX_GENERATOR_MACROS_SVH
`define LATTICE_NEIGHBOUR_INDEX_GENERATOR_MACROS_SVH

`ifndef SYNTH
`define LNIG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lnig assertion failed");
`define LNIG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lnig assertion failed");
`else
`define LNIG_ASSERT_IMP(label, ante, cons)
`define LNIG_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: design/lnig_pkg.sv
// ----------------------------------------------------------------------------
// lnig_pkg
// shared constants, types and neighbour helper for the lattice index generator
// ----------------------------------------------------------------------------
package lnig_pkg;

  localparam int SIDE_LIMIT = 64;
  localparam int LEN_W      = 7;
  localparam int CRD_W      = 6;
  localparam int IDX_W      = 18;
  localparam int SQ_W       = 2 * LEN_W;
  localparam int CUBE_W     = 3 * LEN_W;
  localparam int CNT_W      = 19;
  localparam int DIMS_W     = 2;
  localparam int MASK_W     = 6;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int PY_W       = LEN_W + CRD_W;
  localparam int PZ_W       = SQ_W + CRD_W;
  localparam int RES_W      = 7 * IDX_W + MASK_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [DIMS_W-1:0] DIMS_SQUARE = 2'd2;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_COUNT  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_SIDE     = 2'd0,
    REG_PERIODIC = 2'd1,
    REG_DIMS     = 2'd2,
    REG_COUNT    = 2'd3
  } reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              wrap;
    logic              sq;
    logic [SQ_W-1:0]   l2;
    logic [CUBE_W-1:0] ztop;
  } cfg_t;

  typedef struct packed {
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [CRD_W-1:0] cz;
    logic             last;
    err_t             err;
  } walk_t;

  typedef struct packed {
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [CRD_W-1:0] cz;
    logic [PY_W-1:0]  py;
    logic [PZ_W-1:0]  pz;
    logic             last;
    err_t             err;
  } prod_t;

  typedef struct packed {
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [CRD_W-1:0] cz;
    logic [IDX_W-1:0] idx;
    logic             last;
    err_t             err;
  } site_t;

  typedef struct packed {
    logic [IDX_W-1:0] up;
    logic [IDX_W-1:0] dn;
    logic             mup;
    logic             mdn;
  } nbr_t;

  // up and down neighbour along one axis, delta is span minus stride
  function automatic nbr_t axis_nbr(input logic [IDX_W-1:0] idx,
                                    input logic             at_lo,
                                    input logic             at_hi,
                                    input logic [IDX_W-1:0] stride,
                                    input logic [IDX_W-1:0] delta,
                                    input logic             wrap);
    nbr_t r;
    r.mup = 1'b0;
    r.mdn = 1'b0;
    if (at_lo) begin
      r.up = idx + stride;
      if (wrap) begin
        r.dn = idx + delta;
      end else begin
        r.dn  = '0;
        r.mdn = 1'b1;
      end
    end else if (at_hi) begin
      if (wrap) begin
        r.up = idx - delta;
      end else begin
        r.up  = '0;
        r.mup = 1'b1;
      end
      r.dn = idx - stride;
    end else begin
      r.up = idx + stride;
      r.dn = idx - stride;
    end
    return r;
  endfunction

endpackage

FILE: design/lnig_walk.sv
// ----------------------------------------------------------------------------
// lnig_walk
// lattice validity check, walk position state and first pipeline register
// ----------------------------------------------------------------------------
`include "lattice_neighbour_index_generator_macros.svh"

module lnig_walk import lnig_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] site_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             restart,
  output logic             item_valid,
  input  logic             item_ready,
  output walk_t            item
);

  logic [CRD_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic [CRD_W-1:0]  pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [CRD_W-1:0]  cx, cy, cz;
  logic              item_valid_r;
  walk_t             item_r, item_nxt;
  logic [LEN_W-1:0]  lm1;
  logic [LEN_W-1:0]  min_len;
  logic [CUBE_W-1:0] cube;
  logic              len_big, stale, at_end, acc;
  err_t              err_nxt;

  assign in_ready   = !item_valid_r || item_ready;
  assign acc        = in_valid && in_ready;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  assign lm1     = cfg.len - LEN_W'(1);
  assign min_len = cfg.wrap ? LEN_W'(3) : LEN_W'(2);
  assign len_big = cfg.len > LEN_W'(SIDE_LIMIT);
  assign cube    = {{(CUBE_W-SQ_W){1'b0}}, cfg.l2} * {{(CUBE_W-LEN_W){1'b0}}, cfg.len};

  always_comb begin
    if (cfg.sq) begin
      if (len_big) begin
        err_nxt = ERR_LENGTH;
      end else if (site_count != {{(CNT_W-SQ_W){1'b0}}, cfg.l2}) begin
        err_nxt = ERR_COUNT;
      end else if (cfg.len < min_len) begin
        err_nxt = ERR_LENGTH;
      end else begin
        err_nxt = ERR_OK;
      end
    end else begin
      if (cfg.len < LEN_W'(3) || len_big) begin
        err_nxt = ERR_LENGTH;
      end else if ({{(CUBE_W-CNT_W){1'b0}}, site_count} != cube) begin
        err_nxt = ERR_COUNT;
      end else begin
        err_nxt = ERR_OK;
      end
    end
  end

  always_comb begin
    stale = ({1'b0, pos_x_r} >= cfg.len) || ({1'b0, pos_y_r} >= cfg.len) ||
            (cfg.sq ? (pos_z_r != '0) : ({1'b0, pos_z_r} >= cfg.len));
    if (restart || stale) begin
      cx = '0;
      cy = '0;
      cz = '0;
    end else begin
      cx = pos_x_r;
      cy = pos_y_r;
      cz = pos_z_r;
    end
    at_end = ({1'b0, cx} == lm1) && ({1'b0, cy} == lm1) &&
             (cfg.sq || ({1'b0, cz} == lm1));
    pos_x_nxt = '0;
    pos_y_nxt = '0;
    pos_z_nxt = '0;
    if (at_end) begin
      pos_x_nxt = '0;
    end else if ({1'b0, cx} != lm1) begin
      pos_x_nxt = cx + CRD_W'(1);
      pos_y_nxt = cy;
      pos_z_nxt = cz;
    end else if ({1'b0, cy} != lm1) begin
      pos_y_nxt = cy + CRD_W'(1);
      pos_z_nxt = cz;
    end else begin
      pos_z_nxt = cz + CRD_W'(1);
    end
    item_nxt.cx   = cx;
    item_nxt.cy   = cy;
    item_nxt.cz   = cz;
    item_nxt.last = at_end;
    item_nxt.err  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      pos_z_r      <= '0;
      item_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (acc && err_nxt == ERR_OK) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        pos_z_r <= pos_z_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= item_nxt;
    end
  end

  `LNIG_ASSERT_NXT(a_err_holds_pos, (acc && err_nxt != ERR_OK),
                   ((pos_x_r == $past(pos_x_r)) && (pos_y_r == $past(pos_y_r)) &&
                    (pos_z_r == $past(pos_z_r))))
  `LNIG_ASSERT_NXT(a_last_rewinds, (acc && err_nxt == ERR_OK && at_end),
                   ((pos_x_r == '0) && (pos_y_r == '0) && (pos_z_r == '0)))
  `LNIG_ASSERT_NXT(a_coord_in_range, (acc && err_nxt == ERR_OK),
                   (({1'b0, item_r.cx} < $past(cfg.len)) &&
                    ({1'b0, item_r.cy} < $past(cfg.len))))

endmodule

FILE: design/lnig_index.sv
// ----------------------------------------------------------------------------
// lnig_index
// two pipeline stages: axis stride products, then row-major site index
// ----------------------------------------------------------------------------
module lnig_index import lnig_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_valid,
  output logic  item_ready,
  input  walk_t item,
  output logic  site_valid,
  input  logic  site_ready,
  output site_t site
);

  logic  prod_valid_r, site_valid_r;
  logic  prod_ready;
  prod_t prod_r, prod_nxt;
  site_t site_r, site_nxt;

  assign prod_ready = !site_valid_r || site_ready;
  assign item_ready = !prod_valid_r || prod_ready;
  assign site_valid = site_valid_r;
  assign site       = site_r;

  always_comb begin
    prod_nxt.cx   = item.cx;
    prod_nxt.cy   = item.cy;
    prod_nxt.cz   = item.cz;
    prod_nxt.py   = {{(PY_W-LEN_W){1'b0}}, cfg.len} * {{(PY_W-CRD_W){1'b0}}, item.cy};
    prod_nxt.pz   = {{(PZ_W-SQ_W){1'b0}}, cfg.l2} * {{(PZ_W-CRD_W){1'b0}}, item.cz};
    prod_nxt.last = item.last;
    prod_nxt.err  = item.err;
  end

  always_comb begin
    site_nxt.cx   = prod_r.cx;
    site_nxt.cy   = prod_r.cy;
    site_nxt.cz   = prod_r.cz;
    site_nxt.idx  = {{(IDX_W-CRD_W){1'b0}}, prod_r.cx} +
                    {{(IDX_W-PY_W){1'b0}}, prod_r.py} + prod_r.pz[IDX_W-1:0];
    site_nxt.last = prod_r.last;
    site_nxt.err  = prod_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      site_valid_r <= 1'b0;
    end else begin
      if (item_ready) begin
        prod_valid_r <= item_valid;
      end
      if (prod_ready) begin
        site_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      prod_r <= prod_nxt;
    end
    if (prod_ready && prod_valid_r) begin
      site_r <= site_nxt;
    end
  end

endmodule

FILE: design/lnig_nbr.sv
// ----------------------------------------------------------------------------
// lnig_nbr
// neighbour indices, boundary mask and the result register
// ----------------------------------------------------------------------------
`include "lattice_neighbour_index_generator_macros.svh"

module lnig_nbr import lnig_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             site_valid,
  output logic             site_ready,
  input  site_t            site,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [RES_W-1:0] res_data,
  output logic             res_last,
  output err_t             res_err
);

  logic             valid_r;
  logic [RES_W-1:0] data_r, data_nxt;
  logic             last_r, last_nxt;
  err_t             err_r;
  logic [LEN_W-1:0] lm1;
  logic [IDX_W-1:0] len_x, l2_x;
  nbr_t             nx, ny, nz;
  logic [MASK_W-1:0] mask;

  assign site_ready = !valid_r || res_ready;
  assign res_valid  = valid_r;
  assign res_data   = data_r;
  assign res_last   = last_r;
  assign res_err    = err_r;

  assign lm1   = cfg.len - LEN_W'(1);
  assign len_x = {{(IDX_W-LEN_W){1'b0}}, cfg.len};
  assign l2_x  = {{(IDX_W-SQ_W){1'b0}}, cfg.l2};

  always_comb begin
    nx = axis_nbr(site.idx, site.cx == '0, {1'b0, site.cx} == lm1, IDX_W'(1),
                  {{(IDX_W-LEN_W){1'b0}}, lm1}, cfg.wrap);
    ny = axis_nbr(site.idx, site.cy == '0, {1'b0, site.cy} == lm1, len_x,
                  l2_x - len_x, cfg.wrap);
    nz = axis_nbr(site.idx, site.cz == '0, {1'b0, site.cz} == lm1, l2_x,
                  cfg.ztop[IDX_W-1:0], cfg.wrap);
    if (cfg.sq) begin
      nz = '0;
    end
    mask = {nz.mdn, nz.mup, ny.mdn, ny.mup, nx.mdn, nx.mup};
    if (site.err != ERR_OK) begin
      data_nxt = '0;
      last_nxt = 1'b0;
    end else begin
      data_nxt = {mask, nz.dn, nz.up, ny.dn, ny.up, nx.dn, nx.up, site.idx};
      last_nxt = site.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (site_ready) begin
      valid_r <= site_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (site_ready && site_valid) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
      err_r  <= site.err;
    end
  end

  `LNIG_ASSERT_IMP(a_err_zero_payload, (valid_r && err_r != ERR_OK), ((data_r == '0) && !last_r))
  `LNIG_ASSERT_NXT(a_stall_holds_result, (valid_r && !res_ready), (valid_r && (data_r == $past(data_r)) && (err_r == $past(err_r))))

endmodule

FILE: design/lattice_neighbour_index_generator.sv
// ----------------------------------------------------------------------------
// lattice_neighbour_index_generator
// walks a square or cubic lattice and emits each site with its neighbours
// ----------------------------------------------------------------------------
// usage: configure side length, periodic mode, dimensions and site count over
// the cfg_ port (byte addresses 0, 4, 8, 12) while no transaction is in flight.
// each input transaction on in_ carries a restart flag in in_tdata[0] and
// yields exactly one output transaction on out_: the site index, the up and
// down neighbours along x, y and z, the open-boundary mask in out_tdata, the
// final-site flag in out_tlast and the error code in out_tuser.
// pipeline: four register stages (walk/check, stride product, index sum and
// the neighbour result register); the first loads at the accepting edge, and
// out_tvalid rises once the transaction reaches the result register.
// throughput is one transaction per cycle; the walk position only depends on
// the previous position and a few compares, so in_tready stays high back to
// back as long as the pipeline moves.
// reset returns the configuration to 3x3x3 periodic and the walk to site 0,
// and empties the pipeline.
// when out_tready is low the result register holds its transaction and the
// stages behind it fill up; in_tready drops once all four stages are full.
// ----------------------------------------------------------------------------
module lattice_neighbour_index_generator import lnig_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [DATA_W-1:0]     cfg_pwdata,
  output logic [DATA_W-1:0]     cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [17:0] site, [35:18] x_up, [53:36] x_down, [71:54] y_up, [89:72] y_down,
  // [107:90] z_up, [125:108] z_down, [131:126] boundary_mask, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic [1:0]            out_tuser    // [1:0] error
);

  logic [LEN_W-1:0]  len_r;
  logic              wrap_r;
  logic [DIMS_W-1:0] dims_r;
  logic [CNT_W-1:0]  count_r;
  logic [SQ_W-1:0]   l2_r;
  logic [CUBE_W-1:0] ztop_r, ztop_nxt;
  logic [LEN_W-1:0]  wr_len;
  logic              wr_en;
  reg_t              reg_sel;
  cfg_t              cfg;

  logic              item_valid, item_ready;
  walk_t             item;
  logic              site_valid, site_ready;
  site_t             site;
  logic [RES_W-1:0]  res_data;
  err_t              res_err;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_len     = cfg_pwdata[LEN_W-1:0];
  assign ztop_nxt   = {{(CUBE_W-SQ_W){1'b0}}, l2_r} *
                      {{(CUBE_W-LEN_W){1'b0}}, len_r - LEN_W'(1)};

  always_comb begin
    case (reg_sel)
      REG_SIDE:     cfg_prdata = {{(DATA_W-LEN_W){1'b0}}, len_r};
      REG_PERIODIC: cfg_prdata = {{(DATA_W-1){1'b0}}, wrap_r};
      REG_DIMS:     cfg_prdata = {{(DATA_W-DIMS_W){1'b0}}, dims_r};
      REG_COUNT:    cfg_prdata = {{(DATA_W-CNT_W){1'b0}}, count_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(3);
      wrap_r  <= 1'b1;
      dims_r  <= DIMS_W'(3);
      count_r <= CNT_W'(27);
      l2_r    <= SQ_W'(9);
      ztop_r  <= CUBE_W'(18);
    end else begin
      ztop_r <= ztop_nxt;
      if (wr_en) begin
        case (reg_sel)
          REG_SIDE: begin
            len_r <= wr_len;
            l2_r  <= {{(SQ_W-LEN_W){1'b0}}, wr_len} * {{(SQ_W-LEN_W){1'b0}}, wr_len};
          end
          REG_PERIODIC: wrap_r  <= cfg_pwdata[0];
          REG_DIMS:     dims_r  <= cfg_pwdata[DIMS_W-1:0];
          REG_COUNT:    count_r <= cfg_pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.len  = len_r;
    cfg.wrap = wrap_r;
    cfg.sq   = (dims_r == DIMS_SQUARE);
    cfg.l2   = l2_r;
    cfg.ztop = ztop_r;
  end

  lnig_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .site_count (count_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .restart    (in_tdata[0]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  lnig_index u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .site_valid (site_valid),
    .site_ready (site_ready),
    .site       (site)
  );

  lnig_nbr u_nbr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .site_valid (site_valid),
    .site_ready (site_ready),
    .site       (site),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (res_data),
    .res_last   (out_tlast),
    .res_err    (res_err)
  );

  assign out_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, res_data};
  assign out_tuser = res_err;

endmodule

FILE: sim/lattice_neighbour_index_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice neighbour index checker
// snoops the cfg_ writes and the in_/out_ streams, walks its own copy of the
// lattice for every accepted input transaction and compares each output
// transaction field by field against the oldest predicted site
// ----------------------------------------------------------------------------
module lattice_neighbour_index_checker import lnig_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [DATA_W-1:0]     cfg_pwdata,
  input  logic                  cfg_pready,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [0] restart
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [17:0] site, [35:18] x_up, [53:36] x_down, [71:54] y_up, [89:72] y_down,
  // [107:90] z_up, [125:108] z_down, [131:126] boundary_mask
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic [1:0]            out_tuser,   // [1:0] error
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic [IDX_W-1:0]  site;
    logic [IDX_W-1:0]  x_up;
    logic [IDX_W-1:0]  x_down;
    logic [IDX_W-1:0]  y_up;
    logic [IDX_W-1:0]  y_down;
    logic [IDX_W-1:0]  z_up;
    logic [IDX_W-1:0]  z_down;
    logic [MASK_W-1:0] bmask;
    logic              last;
    err_t              err;
  } site_rec_t;

  site_rec_t sites_due[$];

  int side_len;
  bit wrap_mode;
  int dims_sel;
  int declared_sites;
  int walk_x;
  int walk_y;
  int walk_z;

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    fail_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
             $time, what, got, want, checked);
  endtask

  task automatic check_field(input string what, input logic [IDX_W-1:0] got,
                             input logic [IDX_W-1:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void axis_links(input int idx, input int c, input int len,
                                     input int stride, input int span, input bit wrap,
                                     output int up, output int dn,
                                     output bit wall_up, output bit wall_dn);
    up      = idx + stride;
    dn      = idx - stride;
    wall_up = 1'b0;
    wall_dn = 1'b0;
    if (c == 0) begin
      if (wrap) begin
        dn = idx + span - stride;
      end else begin
        dn      = 0;
        wall_dn = 1'b1;
      end
    end else if (c == len - 1) begin
      if (wrap) begin
        up = idx - span + stride;
      end else begin
        up      = 0;
        wall_up = 1'b1;
      end
    end
  endfunction

  function automatic site_rec_t walk_lattice(input bit restart);
    site_rec_t r;
    int        len;
    int        l2;
    int        l3;
    int        idx;
    int        up;
    int        dn;
    bit        sq;
    bit        wu;
    bit        wd;
    bit        at_end;
    r   = '0;
    len = side_len;
    sq  = (dims_sel == int'(DIMS_SQUARE));
    l2  = len * len;
    l3  = l2 * len;
    if (sq) begin
      if (len > SIDE_LIMIT) begin
        r.err = ERR_LENGTH;
      end else if (declared_sites != l2) begin
        r.err = ERR_COUNT;
      end else if (len < (wrap_mode ? 3 : 2)) begin
        r.err = ERR_LENGTH;
      end
    end else if (len < 3 || len > SIDE_LIMIT) begin
      r.err = ERR_LENGTH;
    end else if (declared_sites != l3) begin
      r.err = ERR_COUNT;
    end
    if (r.err != ERR_OK) begin
      return r;
    end

    // stale coordinates after a resize restart the walk
    if (restart || walk_x >= len || walk_y >= len ||
        (sq ? (walk_z != 0) : (walk_z >= len))) begin
      walk_x = 0;
      walk_y = 0;
      walk_z = 0;
    end
    idx    = walk_x + len * walk_y + l2 * walk_z;
    r.site = IDX_W'(idx);
    axis_links(idx, walk_x, len, 1, len, wrap_mode, up, dn, wu, wd);
    r.x_up     = IDX_W'(up);
    r.x_down   = IDX_W'(dn);
    r.bmask[0] = wu;
    r.bmask[1] = wd;
    axis_links(idx, walk_y, len, len, l2, wrap_mode, up, dn, wu, wd);
    r.y_up     = IDX_W'(up);
    r.y_down   = IDX_W'(dn);
    r.bmask[2] = wu;
    r.bmask[3] = wd;
    if (!sq) begin
      axis_links(idx, walk_z, len, l2, l3, wrap_mode, up, dn, wu, wd);
      r.z_up     = IDX_W'(up);
      r.z_down   = IDX_W'(dn);
      r.bmask[4] = wu;
      r.bmask[5] = wd;
    end
    at_end = (walk_x == len - 1) && (walk_y == len - 1) && (sq || walk_z == len - 1);
    r.last = at_end;

    if (at_end) begin
      walk_x = 0;
      walk_y = 0;
      walk_z = 0;
    end else if (walk_x + 1 < len) begin
      walk_x++;
    end else if (walk_y + 1 < len) begin
      walk_x = 0;
      walk_y++;
    end else begin
      walk_x = 0;
      walk_y = 0;
      walk_z++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    site_rec_t got;
    site_rec_t want;
    if (!rst_n) begin
      sites_due.delete();
      side_len       = 3;
      wrap_mode      = 1'b1;
      dims_sel       = 3;
      declared_sites = 27;
      walk_x         = 0;
      walk_y         = 0;
      walk_z         = 0;
      fail_count     = 0;
      checked        = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.site   = out_tdata[0*IDX_W +: IDX_W];
        got.x_up   = out_tdata[1*IDX_W +: IDX_W];
        got.x_down = out_tdata[2*IDX_W +: IDX_W];
        got.y_up   = out_tdata[3*IDX_W +: IDX_W];
        got.y_down = out_tdata[4*IDX_W +: IDX_W];
        got.z_up   = out_tdata[5*IDX_W +: IDX_W];
        got.z_down = out_tdata[6*IDX_W +: IDX_W];
        got.bmask  = out_tdata[7*IDX_W +: MASK_W];
        got.last   = out_tlast;
        got.err    = err_t'(out_tuser);
        if (sites_due.size() == 0) begin
          report_mismatch("transaction with nothing expected, site", got.site, '0);
        end else begin
          want = sites_due.pop_front();
          check_field("site", got.site, want.site);
          check_field("x_up", got.x_up, want.x_up);
          check_field("x_down", got.x_down, want.x_down);
          check_field("y_up", got.y_up, want.y_up);
          check_field("y_down", got.y_down, want.y_down);
          check_field("z_up", got.z_up, want.z_up);
          check_field("z_down", got.z_down, want.z_down);
          check_field("boundary_mask", IDX_W'(got.bmask), IDX_W'(want.bmask));
          check_field("last", IDX_W'(got.last), IDX_W'(want.last));
          check_field("error", IDX_W'(got.err), IDX_W'(want.err));
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        sites_due.push_back(walk_lattice(in_tdata[0]));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_t'(cfg_paddr[3:2]))
          REG_SIDE:     side_len       = int'(cfg_pwdata[LEN_W-1:0]);
          REG_PERIODIC: wrap_mode      = cfg_pwdata[0];
          REG_DIMS:     dims_sel       = int'(cfg_pwdata[DIMS_W-1:0]);
          REG_COUNT:    declared_sites = int'(cfg_pwdata[CNT_W-1:0]);
          default: ;
        endcase
      end
    end
    pending = sites_due.size();
  end

endmodule

FILE: sim/tb_lattice_neighbour_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_neighbour_index_generator
// drives the lattice walker through square and cubic lattices, periodic and
// open edges, every error code and stale positions after resizing, with
// random gaps on the input and random stalls on the output; the checker
// beside the block predicts and compares every output transaction
// ----------------------------------------------------------------------------
module tb_lattice_neighbour_index_generator import lnig_pkg::*;;

  localparam logic [3:0] ALL_REGS  = 4'hF;
  localparam logic [3:0] SIZE_REGS = 4'b1001;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [ADDR_W-1:0]     cfg_paddr;
  logic [DATA_W-1:0]     cfg_pwdata;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int settings;
  int cur_dims;
  bit cur_per;
  bit tx_burst;
  bit rx_burst;

  lattice_neighbour_index_generator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  lattice_neighbour_index_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("run timed out");
    $display("FAIL");
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_site(input bit restart);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic hold_inputs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input reg_t r, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({r, 2'b00});
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic setup_lattice(input logic [3:0] regs, input int len, input bit per,
                               input int dims, input int cnt);
    hold_inputs();
    if (regs[REG_SIDE]) begin
      apb_write(REG_SIDE, len);
    end
    if (regs[REG_PERIODIC]) begin
      apb_write(REG_PERIODIC, 32'(per));
      cur_per = per;
    end
    if (regs[REG_DIMS]) begin
      apb_write(REG_DIMS, dims);
      cur_dims = dims;
    end
    if (regs[REG_COUNT]) begin
      apb_write(REG_COUNT, cnt);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings++;
  endtask

  initial begin
    int         kind;
    int         len;
    int         dims;
    int         cnt;
    int         n;
    bit         per;
    logic [3:0] regs;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    sent        = 0;
    settings    = 0;
    cur_dims    = 3;
    cur_per     = 1'b1;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset lattice, restart mid walk
    send_site(1'b0);
    send_site(1'b0);
    send_site(1'b1);
    // smallest open square, through the final site and back to zero
    setup_lattice(ALL_REGS, 2, 1'b0, 2, 4);
    repeat (5) send_site(1'b0);
    // error results leave the walk alone, restart included
    setup_lattice(ALL_REGS, 2, 1'b1, 2, 4);
    send_site(1'b1);
    setup_lattice(ALL_REGS, 2, 1'b1, 3, 8);
    send_site(1'b0);
    setup_lattice(ALL_REGS, 65, 1'b1, 3, 0);
    send_site(1'b1);
    setup_lattice(ALL_REGS, 127, 1'b0, 0, 0);
    send_site(1'b0);
    setup_lattice(ALL_REGS, 3, 1'b1, 2, 8);
    send_site(1'b0);
    setup_lattice(ALL_REGS, 64, 1'b1, 3, 524287);
    send_site(1'b0);
    // largest cube, wrap across every axis and then open walls; largest open square, zero side
    setup_lattice(ALL_REGS, 64, 1'b1, 3, 262144);
    send_site(1'b1);
    send_site(1'b0);
    setup_lattice(ALL_REGS, 64, 1'b0, 3, 262144);
    send_site(1'b1);
    setup_lattice(ALL_REGS, 64, 1'b0, 2, 4096);
    send_site(1'b0);
    send_site(1'b0);
    setup_lattice(ALL_REGS, 0, 1'b0, 2, 0);
    send_site(1'b0);
    // shrink below the stored position, odd dimension codes
    setup_lattice(ALL_REGS, 3, 1'b1, 1, 27);
    send_site(1'b0);
    send_site(1'b0);
    setup_lattice(ALL_REGS, 4, 1'b0, 0, 64);
    send_site(1'b0);

    while (sent < 1550) begin
      kind     = $urandom_range(0, 9);
      per      = 1'($urandom_range(0, 1));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      regs     = ALL_REGS;
      case (kind)
        0, 1, 2: begin
          dims = 2;
          len  = $urandom_range(2, 8);
          n    = $urandom_range(20, 80);
        end
        3, 4, 5: begin
          dims = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 3;
          len  = $urandom_range(3, 5);
          n    = $urandom_range(30, 140);
        end
        6: begin
          dims = ($urandom_range(0, 1) == 0) ? 2 : 3;
          len  = $urandom_range(60, 64);
          n    = $urandom_range(10, 60);
        end
        7: begin
          dims = $urandom_range(0, 3);
          len  = $urandom_range(0, 127);
          n    = $urandom_range(3, 12);
        end
        default: begin
          dims = cur_dims;
          per  = cur_per;
          len  = $urandom_range(2, 6);
          regs = SIZE_REGS;
          n    = $urandom_range(20, 60);
        end
      endcase
      cnt = (dims == 2) ? len * len : len * len * len;
      if (kind == 7) begin
        if ($urandom_range(0, 2) == 0) begin
          cnt = cnt + 1;
        end else if ($urandom_range(0, 1) == 0) begin
          cnt = $urandom_range(0, 524287);
        end
      end
      setup_lattice(regs, len, per, dims, cnt);
      repeat (n) begin
        send_site($urandom_range(0, 29) == 0);
        if ($urandom_range(0, 199) == 0) begin
          hold_inputs();
        end
      end
    end

    hold_inputs();
    repeat (12) @(negedge clk);
    $display("%0d input transactions over %0d lattice settings, %0d results checked",
             sent, settings, checked);
    $display("covered square and cubic walks, periodic and open edges, error codes, resizing");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("FAIL");
    end
    $finish;
  end

endmodule
